// ===== sv/rbs_pkg.sv =====
// rbs_pkg: shared types and constants of the record bubble sorter
// record layout, write-data select codes and controller-to-datapath command
// no dependencies
package rbs_pkg;

	localparam int MAX_RECORDS_DEF = 32;
	localparam int ID_W            = 32;
	localparam int AGE_W           = 8;
	localparam int TAG_W           = 16;

	typedef struct packed {
		logic signed [ID_W-1:0] id;
		logic [AGE_W-1:0]       age;
		logic [TAG_W-1:0]       tag;
	} rec_t;

	typedef enum logic [1:0] {
		WSEL_IN    = 2'd0,
		WSEL_SCAN  = 2'd1,
		WSEL_CARRY = 2'd2
	} wsel_t;

	typedef struct packed {
		logic  wr_en;
		wsel_t wr_sel;
		logic  carry_first;
		logic  carry_scan;
		logic  out_ld;
		logic  out_last;
		logic  out_ovf;
	} cmd_t;

endpackage

// ===== sv/rbs_in_if.sv =====
// rbs_in_if: record input channel, valid/ready with one record per transfer
// depends on rbs_pkg for field widths
interface rbs_in_if;
	logic                           valid;
	logic                           ready;
	logic signed [rbs_pkg::ID_W-1:0] rec_id;
	logic [rbs_pkg::AGE_W-1:0]      rec_age;
	logic [rbs_pkg::TAG_W-1:0]      rec_tag;
	logic                           last_in;

	modport source (output valid, rec_id, rec_age, rec_tag, last_in, input ready);
	modport sink   (input valid, rec_id, rec_age, rec_tag, last_in, output ready);
endinterface

// ===== sv/rbs_out_if.sv =====
// rbs_out_if: sorted record output channel, valid/ready
// depends on rbs_pkg for field widths
interface rbs_out_if;
	logic                           valid;
	logic                           ready;
	logic signed [rbs_pkg::ID_W-1:0] out_id;
	logic [rbs_pkg::AGE_W-1:0]      out_age;
	logic [rbs_pkg::TAG_W-1:0]      out_tag;
	logic                           out_last;
	logic                           out_overflow;

	modport source (output valid, out_id, out_age, out_tag, out_last, out_overflow,
		input ready);
	modport sink   (input valid, out_id, out_age, out_tag, out_last, out_overflow,
		output ready);
endinterface

// ===== sv/rbs_datapath.sv =====
// rbs_datapath: record memory, bubble carry register, key compare, output register
// depends on rbs_pkg; driven by rbs_ctrl commands
module rbs_datapath #(
	parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF,
	localparam int IDX_W = $clog2(MAX_RECORDS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  rbs_pkg::cmd_t       cmd,
	input  logic [IDX_W-1:0]    wr_addr,
	input  logic [IDX_W-1:0]    rd_addr,
	input  rbs_pkg::rec_t       in_rec,
	output rbs_pkg::rec_t       out_rec,
	output logic                out_last,
	output logic                out_ovf
);

	rbs_pkg::rec_t mem [MAX_RECORDS];
	rbs_pkg::rec_t rd_q;
	rbs_pkg::rec_t carry_q;
	rbs_pkg::rec_t wdata;
	rbs_pkg::rec_t out_rec_q;
	logic          out_last_q;
	logic          out_ovf_q;
	logic          key_q;
	logic          gt;

	// strict greater keeps equal keys in arrival order
	assign gt = key_q ? (carry_q.age > rd_q.age) : (carry_q.id > rd_q.id);

	always_comb begin
		case (cmd.wr_sel)
			rbs_pkg::WSEL_IN:    wdata = in_rec;
			rbs_pkg::WSEL_SCAN:  wdata = gt ? rd_q : carry_q;
			rbs_pkg::WSEL_CARRY: wdata = carry_q;
			default:             wdata = carry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.carry_first) begin
			carry_q <= rd_q;
		end else if (cmd.carry_scan && !gt) begin
			carry_q <= rd_q;
		end
		if (cmd.out_ld) begin
			out_rec_q  <= rd_q;
			out_last_q <= cmd.out_last;
			out_ovf_q  <= cmd.out_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= 1'b0;
		end else if (cfg_we) begin
			key_q <= cfg_wdata;
		end
	end

	assign out_rec  = out_rec_q;
	assign out_last = out_last_q;
	assign out_ovf  = out_ovf_q;

endmodule

// ===== sv/rbs_ctrl.sv =====
// rbs_ctrl: sequencer for load, bubble passes and emission
// depends on rbs_pkg; issues commands and addresses to rbs_datapath
module rbs_ctrl #(
	parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF,
	localparam int IDX_W = $clog2(MAX_RECORDS),
	localparam int CNT_W = $clog2(MAX_RECORDS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_last,
	output logic             out_valid,
	input  logic             out_ready,
	output rbs_pkg::cmd_t    cmd,
	output logic [IDX_W-1:0] wr_addr,
	output logic [IDX_W-1:0] rd_addr
);

	typedef enum logic [7:0] {
		ST_LOAD   = 8'b0000_0001,
		ST_PSTART = 8'b0000_0010,
		ST_PFIRST = 8'b0000_0100,
		ST_SCAN   = 8'b0000_1000,
		ST_PEND   = 8'b0001_0000,
		ST_ERD    = 8'b0010_0000,
		ST_ELD    = 8'b0100_0000,
		ST_EOUT   = 8'b1000_0000
	} state_t;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
	logic             ovf_q, ovf_d;
	logic [IDX_W-1:0] lim_q, lim_d;
	logic [IDX_W-1:0] j_q, j_d;
	logic [IDX_W-1:0] k_q, k_d;
	logic             in_xfer, out_xfer, room, k_last;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EOUT);
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid && out_ready;
	assign room      = (cnt_q < MAX_CNT);
	assign cnt_inc   = cnt_q + CNT_W'(room);
	assign k_last    = ((CNT_W'(k_q) + CNT_W'(1)) == cnt_q);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		lim_d   = lim_q;
		j_d     = j_q;
		k_d     = k_q;
		cmd     = '0;
		cmd.wr_sel = rbs_pkg::WSEL_IN;
		wr_addr = '0;
		rd_addr = '0;
		case (state_q)
			ST_LOAD: begin
				wr_addr = cnt_q[IDX_W-1:0];
				if (in_xfer) begin
					cmd.wr_en = room;
					cnt_d     = cnt_inc;
					if (!room) begin
						ovf_d = 1'b1;
					end
					if (in_last) begin
						k_d   = '0;
						lim_d = IDX_W'(cnt_inc - CNT_W'(1));
						if (cnt_inc >= CNT_W'(2)) begin
							state_d = ST_PSTART;
						end else begin
							state_d = ST_ERD;
						end
					end
				end
			end
			ST_PSTART: begin
				rd_addr = '0;
				state_d = ST_PFIRST;
			end
			ST_PFIRST: begin
				cmd.carry_first = 1'b1;
				rd_addr = IDX_W'(1);
				j_d     = IDX_W'(1);
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_sel     = rbs_pkg::WSEL_SCAN;
				cmd.carry_scan = 1'b1;
				wr_addr = j_q - IDX_W'(1);
				if (j_q == lim_q) begin
					state_d = ST_PEND;
				end else begin
					rd_addr = j_q + IDX_W'(1);
					j_d     = j_q + IDX_W'(1);
				end
			end
			ST_PEND: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = rbs_pkg::WSEL_CARRY;
				wr_addr = lim_q;
				if (lim_q > IDX_W'(1)) begin
					lim_d   = lim_q - IDX_W'(1);
					state_d = ST_PSTART;
				end else begin
					state_d = ST_ERD;
				end
			end
			ST_ERD: begin
				rd_addr = k_q;
				state_d = ST_ELD;
			end
			ST_ELD: begin
				cmd.out_ld   = 1'b1;
				cmd.out_last = k_last;
				cmd.out_ovf  = ovf_q;
				state_d = ST_EOUT;
			end
			ST_EOUT: begin
				if (out_xfer) begin
					if (k_last) begin
						cnt_d   = '0;
						ovf_d   = 1'b0;
						state_d = ST_LOAD;
					end else begin
						k_d     = k_q + IDX_W'(1);
						state_d = ST_ERD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			lim_q   <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			lim_q   <= lim_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

endmodule

// ===== sv/record_bubble_sorter_top.sv =====
// record_bubble_sorter_top: load one record per cycle, stable bubble sort, emit.
// sort: each pass runs PSTART, PFIRST, SCAN over the unsorted part and PEND,
//   one memory port pair per compare step; each pass is one record shorter
// emission: ERD reads, ELD loads the output register, EOUT holds the record until taken
// throughput: one set at a time, no new record transfer until the last result is taken
// reset: arst_n clears control, count, overflow and key select; record memory is not cleared
module record_bubble_sorter_top #(
	parameter int MAX_RECORDS = rbs_pkg::MAX_RECORDS_DEF,
	localparam int IDX_W = $clog2(MAX_RECORDS)
) (
	input  logic        clk,
	input  logic        arst_n,
	rbs_in_if.sink      records,
	rbs_out_if.source   sorted,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	rbs_pkg::cmd_t    cmd;
	rbs_pkg::rec_t    in_rec;
	rbs_pkg::rec_t    out_rec;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	logic             out_last;
	logic             out_ovf;

	// incoming record as one packed word for the memory write port
	assign in_rec.id  = records.rec_id;
	assign in_rec.age = records.rec_age;
	assign in_rec.tag = records.rec_tag;

	// sequencer: counts records, walks bubble passes, steps the emission
	rbs_ctrl #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (records.valid),
		.in_ready  (records.ready),
		.in_last   (records.last_in),
		.out_valid (sorted.valid),
		.out_ready (sorted.ready),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	// memory, carry register and key compare; output fields come from its register
	rbs_datapath #(
		.MAX_RECORDS (MAX_RECORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.in_rec    (in_rec),
		.out_rec   (out_rec),
		.out_last  (out_last),
		.out_ovf   (out_ovf)
	);

	assign sorted.out_id       = out_rec.id;
	assign sorted.out_age      = out_rec.age;
	assign sorted.out_tag      = out_rec.tag;
	assign sorted.out_last     = out_last;
	assign sorted.out_overflow = out_ovf;

	// loading and emission never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(records.ready && sorted.valid))
		else $error("input ready while a sorted record is shown");

	// a transfer marked last closes the load phase
	a_last_in_closes: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && records.ready && records.last_in |=> !records.ready)
		else $error("still loading after the last record");

	// the final sorted transfer reopens loading
	a_last_out_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		sorted.valid && sorted.ready && sorted.out_last |=> records.ready && !sorted.valid)
		else $error("not back to loading after the final record");

	// a non-final transfer does not reopen loading
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		sorted.valid && sorted.ready && !sorted.out_last |=> !records.ready)
		else $error("loading resumed before the set was fully emitted");

endmodule
